[hw/rtl/piecewise_linear_table_lookup_core_assert.svh]
// Assertion macros for the piecewise-linear table lookup core.
`ifndef PIECEWISE_LINEAR_TABLE_LOOKUP_CORE_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_LOOKUP_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on each clock edge outside reset.
`define PLLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pllt: assertion failed");
// Check a property on each clock edge, reset included.
`define PLLT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pllt: assertion failed");
`else
`define PLLT_ASSERT(lbl, prop)
`define PLLT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[hw/rtl/pllt_pkg.sv]
// Shared types and constants for the piecewise-linear table lookup core.
package pllt_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W        = 32;
  localparam int CNT_W         = 7;
  localparam int IDX_W         = 6;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DIFF,
    ST_MUL,
    ST_LAUNCH,
    ST_DIV,
    ST_REPLY
  } st_t;

  // Request to the serial divider: dividend split in halves, high half < divisor
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

endpackage

[hw/rtl/piecewise_linear_table_lookup_core.sv]
// A load is taken while idle and busy stays low; a query keeps busy high to its reply.
// A query scans the entries in order, reading then comparing each; the scan ends
// on an exact hit, a larger x or the last entry. Interpolation adds the difference,
// multiply and launch steps and the serial divider, which set the worst-case query time.
// Synchronous active-high reset clears the sequencer and point_count; table contents
// stay undefined until loaded. Results are strobed on done for one cycle, no stall.
`include "piecewise_linear_table_lookup_core_assert.svh"
module piecewise_linear_table_lookup_core #(
  parameter int TABLE_DEPTH = pllt_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pllt_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [pllt_pkg::IDX_W-1:0]          entry_index,
  input  logic signed [pllt_pkg::DATA_W-1:0]  point_x,
  input  logic signed [pllt_pkg::DATA_W-1:0]  point_y,
  output logic                                done,
  output logic signed [pllt_pkg::DATA_W-1:0]  value_y,
  output logic                                found,
  output logic                                exact_hit
);
  import pllt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  st_t state;
  st_t state_next;

  logic [CNT_W-1:0]         point_count;
  logic [NW-1:0]            n;
  logic [NW-1:0]            n_in;
  logic [AW-1:0]            i;
  logic                     last;
  logic                     idx_ok;

  logic signed [DATA_W-1:0] x_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] y_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_x;
  logic signed [DATA_W-1:0] rd_y;

  logic signed [DATA_W-1:0] qx;
  logic signed [DATA_W-1:0] prev_x;
  logic signed [DATA_W-1:0] prev_y;
  logic [DATA_W-1:0]        t;
  logic [DATA_W-1:0]        dx;
  logic [DATA_W-1:0]        mag;
  logic                     neg;
  logic                     neg_c;
  logic [2*DATA_W-1:0]      prod;

  logic signed [DATA_W-1:0] res_y;
  logic                     res_found;
  logic                     res_exact;

  logic                     hit_eq;
  logic                     hit_gt;
  logic                     accept;

  logic                     div_start;
  div_req_t                 div_req;
  logic                     div_done;
  logic [DATA_W-1:0]        div_quot;

  // Clamp the configured count to the table depth
  always_comb begin
    if (32'(point_count) > 32'(TABLE_DEPTH)) begin
      n_in = NW'(TABLE_DEPTH);
    end else begin
      n_in = NW'(point_count);
    end
  end

  assign accept = start && !busy;
  assign idx_ok = 32'(entry_index) < 32'(TABLE_DEPTH);
  assign last   = (NW'(i) + NW'(1)) == n;
  assign hit_eq = rd_x == qx;
  assign hit_gt = rd_x > qx;
  assign neg_c  = rd_y < prev_y;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_QUERY) begin
          state_next = (n_in == '0) ? ST_REPLY : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (hit_eq) begin
          state_next = ST_REPLY;
        end else if (hit_gt) begin
          state_next = (i == '0) ? ST_REPLY : ST_DIFF;
        end else if (last) begin
          state_next = ST_REPLY;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DIFF: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE:   busy      = 1'b0;
      ST_LAUNCH: div_start = 1'b1;
      ST_REPLY:  done      = 1'b1;
      default:   busy      = 1'b1;
    endcase
  end

  // Pack the divider request: start, product high and low halves, divisor
  assign div_req = {div_start, prod, dx};

  assign value_y   = res_y;
  assign found     = res_found;
  assign exact_hit = res_exact;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
    end
  end

  // Table memory: write on load, registered read at the scan index
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && mode == MODE_LOAD && idx_ok) begin
      x_mem[AW'(entry_index)] <= point_x;
      y_mem[AW'(entry_index)] <= point_y;
    end
    rd_x <= x_mem[i];
    rd_y <= y_mem[i];
  end

  // Scan, interpolation and result datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_QUERY) begin
          qx        <= point_x;
          n         <= n_in;
          i         <= '0;
          res_y     <= '0;
          res_found <= 1'b0;
          res_exact <= 1'b0;
        end
      end
      ST_CMP: begin
        if (hit_eq) begin
          res_y     <= rd_y;
          res_found <= 1'b1;
          res_exact <= 1'b1;
        end else if (hit_gt) begin
          res_found <= 1'b1;
          if (i == '0) begin
            res_y <= rd_y;
          end
        end else begin
          prev_x <= rd_x;
          prev_y <= rd_y;
          i      <= i + AW'(1);
        end
      end
      ST_DIFF: begin
        t   <= DATA_W'(qx - prev_x);
        dx  <= DATA_W'(rd_x - prev_x);
        neg <= neg_c;
        mag <= neg_c ? DATA_W'(prev_y - rd_y) : DATA_W'(rd_y - prev_y);
      end
      ST_MUL: begin
        prod <= (2*DATA_W)'(mag) * (2*DATA_W)'(t);
      end
      ST_DIV: begin
        if (div_done) begin
          res_y <= neg ? prev_y - $signed(div_quot) : prev_y + $signed(div_quot);
        end
      end
      default: begin
      end
    endcase
  end

  pllt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // Checks
  `PLLT_ASSERT(a_reply_then_idle, done |=> !busy)
  `PLLT_ASSERT(a_exact_implies_found, done && exact_hit |-> found)
  `PLLT_ASSERT(a_div_only_in_wait, div_done |-> state == ST_DIV)
  `PLLT_ASSERT(a_query_goes_busy, accept && mode == MODE_QUERY |=> busy)
  `PLLT_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done)

endmodule

[hw/rtl/pllt_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module pllt_div (
  input  logic                           clk,
  input  logic                           rst,
  input  pllt_pkg::div_req_t             req,
  output logic                           done,
  output logic [pllt_pkg::DATA_W-1:0]    quot
);
  import pllt_pkg::*;

  localparam int STEP_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] divisor;
  logic [STEP_W-1:0] step;
  logic              running;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  assign shifted = {rem, acc[DATA_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};
  assign quot    = acc;

  // Control: run for one step per quotient bit, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DATA_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.hi;
      acc     <= req.lo;
      divisor <= req.divisor;
    end else if (running) begin
      rem <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      acc <= {acc[DATA_W-2:0], fits};
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the piecewise-linear table lookup core.
module tb;
  import pllt_pkg::*;

  localparam int TABLE_SLOTS    = DEPTH_DEFAULT;
  localparam int RANDOM_OPS     = 1450;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct packed {
    logic signed [DATA_W-1:0] query_x;
    logic signed [DATA_W-1:0] value;
    logic                     found;
    logic                     exact;
  } lookup_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [CNT_W-1:0]         cfg_wdata;
  logic                     start;
  logic                     busy;
  logic                     mode;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic                     done;
  logic signed [DATA_W-1:0] value_y;
  logic                     found;
  logic                     exact_hit;

  // Table mirror and register copy used for prediction
  logic signed [DATA_W-1:0] x_points [TABLE_SLOTS];
  logic signed [DATA_W-1:0] y_points [TABLE_SLOTS];
  logic [CNT_W-1:0]         point_count_model;
  lookup_t                  pending_lookups [$];

  bit gaps_on;
  int mismatch_count;
  int stall_cycles;
  int ops_total, loads_sent, queries_sent, settings_used;
  int exact_seen, interp_seen, first_point_seen, miss_seen;

  piecewise_linear_table_lookup_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .entry_index (entry_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .done        (done),
    .value_y     (value_y),
    .found       (found),
    .exact_hit   (exact_hit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Linear interpolation between two breakpoints, quotient truncated toward zero
  function automatic logic signed [DATA_W-1:0] interp_q16(input longint x0, input longint y0,
                                                          input longint x1, input longint y1,
                                                          input longint qx);
    longint unsigned t, dx, mag, quo;
    longint dy, r;
    t   = qx - x0;
    dx  = x1 - x0;
    dy  = y1 - y0;
    mag = (dy < 0) ? -dy : dy;
    quo = (mag * t) / dx;
    r   = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
    return DATA_W'(r);
  endfunction

  // Scan the mirrored table the way the core does and return the expected reply
  function automatic lookup_t predict_lookup(input logic signed [DATA_W-1:0] qx);
    lookup_t res;
    int n;
    res = '0;
    res.query_x = qx;
    n = (point_count_model > TABLE_SLOTS) ? TABLE_SLOTS : point_count_model;
    for (int i = 0; i < n; i++) begin
      if (x_points[i] == qx) begin
        res.value = y_points[i];
        res.found = 1'b1;
        res.exact = 1'b1;
        exact_seen++;
        return res;
      end
      if (x_points[i] > qx) begin
        if (i > 0) begin
          res.value = interp_q16(x_points[i-1], y_points[i-1], x_points[i], y_points[i], qx);
          interp_seen++;
        end else begin
          res.value = y_points[0];
          first_point_seen++;
        end
        res.found = 1'b1;
        return res;
      end
    end
    miss_seen++;
    return res;
  endfunction

  function automatic void note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got,
                                        input logic [DATA_W-1:0] qx);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("tb: mismatch on %s for query x %h: expected %h, got %h", what, qx, want, got);
  endfunction

  // Send one transaction, hold it until accepted, then update the mirror
  task automatic drive_op(input logic m, input logic [IDX_W-1:0] idx,
                          input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py);
    if (gaps_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 60)) @(posedge clk);
      else
        repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    entry_index <= idx;
    point_x     <= px;
    point_y     <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
    ops_total++;
    if (m == MODE_LOAD) begin
      x_points[idx] = px;
      y_points[idx] = py;
      loads_sent++;
    end else begin
      pending_lookups.push_back(predict_lookup(px));
      queries_sent++;
    end
  endtask

  // Drop start and wait until every outstanding reply has come back
  task automatic drain_lookups();
    start <= 1'b0;
    do @(negedge clk); while (pending_lookups.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [CNT_W-1:0] count);
    drain_lookups();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    point_count_model = count;
    settings_used++;
  endtask

  // Load n ascending breakpoints from slot 0, sometimes in reverse slot order
  task automatic load_sorted_table(input int n);
    longint unsigned prefix [TABLE_SLOTS];
    longint unsigned total, slack, offset, r64;
    logic [DATA_W-1:0] xv, yv;
    int spacing, yshape, slot;
    bit reversed;
    spacing  = $urandom_range(0, 2);
    yshape   = $urandom_range(0, 2);
    reversed = ($urandom_range(0, 9) == 0);
    total    = 0;
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        case (spacing)
          0:       total += $urandom_range(1, 4);
          1:       total += $urandom_range(1, 32'h0002_0000);
          default: total += $urandom_range(1, 32'h03FF_FFFF);
        endcase
      end
      prefix[k] = total;
    end
    // Place the span at the bottom, the top, or anywhere in the x range
    slack = 64'hFFFF_FFFF - total;
    case ($urandom_range(0, 3))
      0:       offset = 0;
      1:       offset = slack;
      default: begin
        r64    = $urandom;
        offset = r64 % (slack + 1);
      end
    endcase
    yv = $urandom;
    for (int k = 0; k < n; k++) begin
      xv = DATA_W'(offset + prefix[k]) ^ 32'h8000_0000;
      case (yshape)
        0:       yv = $urandom;
        1: begin
          case ($urandom_range(0, 2))
            0:       yv = 32'h7FFF_FFFF;
            1:       yv = 32'h8000_0000;
            default: yv = $urandom;
          endcase
        end
        default: yv = yv + $urandom_range(0, 32'h0003_FFFF) - 32'h0001_FFFF;
      endcase
      slot = reversed ? n - 1 - k : k;
      drive_op(MODE_LOAD, IDX_W'(slot), xv, yv);
    end
  endtask

  // Pick a query x: on a breakpoint, between two, outside the table, or anywhere
  function automatic logic [DATA_W-1:0] choose_query_x(input int n);
    longint lo, hi, q, r;
    int k, sel;
    sel = $urandom_range(0, 99);
    if (n == 0 || sel >= 90) begin
      case ($urandom_range(0, 4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        default: return $urandom;
      endcase
    end
    k  = $urandom_range(0, n - 1);
    lo = x_points[k];
    if (sel < 25)
      return x_points[k];
    if (sel < 60 && k < n - 1) begin
      hi = x_points[k+1];
      r  = $urandom;
      if (hi - lo > 1)
        return DATA_W'(lo + 1 + (r % (hi - lo - 1)));
      return DATA_W'(lo + 1);
    end
    if (sel < 75) begin
      q = longint'(x_points[0]) - 1 - longint'($urandom_range(0, 15));
      return (q < -64'sd2147483648) ? 32'h8000_0000 : DATA_W'(q);
    end
    q = longint'(x_points[n-1]) + 1 + longint'($urandom_range(0, 15));
    return (q > 64'sd2147483647) ? 32'h7FFF_FFFF : DATA_W'(q);
  endfunction

  // One table setting: write the count, fill the table, then mixed traffic
  task automatic run_phase(input logic [CNT_W-1:0] count, input int n_ops);
    int n;
    set_point_count(count);
    n = (count > TABLE_SLOTS) ? TABLE_SLOTS : count;
    if (n > 0)
      load_sorted_table(n);
    repeat (n_ops) begin
      if ($urandom_range(99) < 12)
        drive_op(MODE_LOAD, IDX_W'($urandom), $urandom, $urandom);
      else
        drive_op(MODE_QUERY, IDX_W'($urandom), choose_query_x(n), $urandom);
    end
  endtask

  task automatic test_empty_table();
    set_point_count(CNT_W'(0));
    drive_op(MODE_QUERY, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    drive_op(MODE_QUERY, '1, 32'h0000_0000, 32'h8000_0000);
    drive_op(MODE_QUERY, '0, 32'h7FFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_breakpoints();
    // Full-range segments with the largest possible y swing
    drive_op(MODE_LOAD, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    drive_op(MODE_LOAD, 6'd1, 32'h0000_0000, 32'h8000_0000);
    drive_op(MODE_LOAD, 6'd2, 32'h0003_0000, 32'h0005_0000);
    drive_op(MODE_LOAD, 6'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drive_op(MODE_LOAD, 6'd63, 32'h1234_5678, 32'hFEDC_BA98);
    set_point_count(CNT_W'(4));
    drive_op(MODE_QUERY, '0, 32'h8000_0000, '0);
    drive_op(MODE_QUERY, '0, 32'hFFFF_FFFF, '0);
    drive_op(MODE_QUERY, '0, 32'h0000_0000, '0);
    drive_op(MODE_QUERY, '0, 32'h0001_8000, '0);
    drive_op(MODE_QUERY, '0, 32'h7FFF_FFFE, '0);
    drive_op(MODE_QUERY, '0, 32'h7FFF_FFFF, '0);
    // Query below the first point, then beyond the last one
    drive_op(MODE_LOAD, 6'd0, 32'hFFFF_0000, 32'h1234_5678);
    set_point_count(CNT_W'(2));
    drive_op(MODE_QUERY, '0, 32'h8000_0000, '0);
    drive_op(MODE_QUERY, '0, 32'h0000_0001, '0);
    // Out-of-order entry: the scan stops at the first larger x
    drive_op(MODE_LOAD, 6'd2, 32'hFFFF_FFFE, 32'h0000_0100);
    set_point_count(CNT_W'(3));
    drive_op(MODE_QUERY, '0, 32'hFFFF_FFFF, '0);
    drive_op(MODE_QUERY, '0, 32'h0000_0005, '0);
    drive_op(MODE_QUERY, '0, 32'hFFFF_FFFE, '0);
  endtask

  task automatic test_count_clamp();
    run_phase(7'd127, 12);
    run_phase(7'd65, 6);
    run_phase(7'd64, 8);
  endtask

  task automatic test_random_lookups();
    int first, r;
    logic [CNT_W-1:0] c;
    first = ops_total;
    while (ops_total - first < RANDOM_OPS) begin
      // Run a stretch with the sender never pausing
      gaps_on = !(ops_total - first >= 500 && ops_total - first < 850);
      r = $urandom_range(0, 99);
      if (r < 6)       c = CNT_W'(0);
      else if (r < 55) c = CNT_W'($urandom_range(1, 8));
      else if (r < 78) c = CNT_W'($urandom_range(9, 24));
      else if (r < 88) c = CNT_W'($urandom_range(25, 63));
      else if (r < 94) c = CNT_W'(64);
      else             c = CNT_W'($urandom_range(65, 127));
      run_phase(c, $urandom_range(10, 30));
    end
    gaps_on = 1'b1;
  endtask

  // Compare each reply with the oldest outstanding query
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && done) begin
      if (pending_lookups.size() == 0) begin
        note_mismatch("reply with no query outstanding", '0, value_y, '0);
      end else begin
        want = pending_lookups.pop_front();
        if (value_y !== want.value)
          note_mismatch("value_y", want.value, value_y, want.query_x);
        if (found !== want.found)
          note_mismatch("found", want.found, found, want.query_x);
        if (exact_hit !== want.exact)
          note_mismatch("exact_hit", want.exact, exact_hit, want.query_x);
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: no transaction for %0d cycles, giving up", WATCHDOG_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    start             = 1'b0;
    mode              = MODE_LOAD;
    entry_index       = '0;
    point_x           = '0;
    point_y           = '0;
    point_count_model = '0;
    gaps_on           = 1'b1;
    stall_cycles      = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_breakpoints();
    test_count_clamp();
    test_random_lookups();

    drain_lookups();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      $display("tb: %0d queries never answered", pending_lookups.size());
      mismatch_count += pending_lookups.size();
    end

    $display("tb: %0d loads and %0d queries over %0d table settings", loads_sent,
             queries_sent, settings_used);
    $display("tb: replies: %0d exact, %0d interpolated, %0d first point, %0d not found",
             exact_seen, interp_seen, first_point_seen, miss_seen);
    if (mismatch_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
